@@ design/assert_macros.svh @@
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ design/caai_pkg.sv @@
// shared widths, codes and types for the adc to angle interpolator
`timescale 1ns / 1ps
`default_nettype none

package caai_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int JOINT_W  = 4;
	localparam int PIDX_W   = 5;
	localparam int CODE_W   = 16;
	localparam int ANGLE_W  = 16;
	localparam int SAMPLE_W = 12;
	localparam int FRAC_W   = 4;
	localparam int STATUS_W = 2;

	// interpolation arithmetic: angle times code difference, then sum of two
	localparam int DIFF_W    = CODE_W + 1;
	localparam int PROD_W    = ANGLE_W + DIFF_W;
	localparam int NUM_W     = PROD_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// item operations
	localparam logic [OP_W-1:0] OP_LOAD_BREAK = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_ANGLE = 2'd1;
	localparam logic [OP_W-1:0] OP_CONVERT    = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_INTERP = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EXACT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BELOW  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_ABOVE  = 2'd3;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

@@ design/caai_div.sv @@
// serial signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module caai_div import caai_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [NUM_W-1:0]   num,
	input  wire logic        [CODE_W-1:0]  den,
	output      div_stat_t                 stat,
	output      logic signed [ANGLE_W-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [CODE_W-1:0]    den_q;
	logic [CODE_W-1:0]    rem_q;
	logic [NUM_W-1:0]     mag_q;

	logic [CODE_W:0]      shifted;
	logic [CODE_W+1:0]    trial;
	logic                 fits;

	// restoring step: shift in the next numerator bit, try to subtract
	always_comb begin
		shifted = {rem_q, mag_q[NUM_W-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
		fits    = !trial[CODE_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: magnitude register turns into the quotient bit by bit
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			den_q <= den;
			rem_q <= '0;
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		end else if (busy_q) begin
			rem_q <= fits ? trial[CODE_W-1:0] : shifted[CODE_W-1:0];
			mag_q <= {mag_q[NUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot = neg_q ? $signed(ANGLE_W'(-mag_q)) : $signed(ANGLE_W'(mag_q));

	`ASSERT_NEVER(a_start_busy, clk, arst_n, start && busy_q, "divider started while busy")
	`ASSERT_PROP(a_done_follows, clk, arst_n, busy_q && (cnt_q == '0) |=> done_q && !busy_q,
		"divider did not finish after last step")
	`ASSERT_PROP(a_done_from_busy, clk, arst_n, done_q |-> $past(busy_q),
		"divider done without a running division")

endmodule

`default_nettype wire

@@ design/calibrated_adc_to_angle_interp.sv @@
// top level: calibration tables, scan sequencer and interpolation datapath
//
// Converts a 12-bit servo feedback sample into a joint angle in 1/64 degree by
// piecewise linear lookup: breakpoints are per joint and per direction, the
// angle points are one table shared by all joints and directions.
// Load items (op 0 breakpoint, op 1 angle point) produce no result; op 3, a
// breakpoint load or convert with an out-of-range joint, and a load with an
// out-of-range point index are dropped. A convert item walks its curve one
// breakpoint at a time through the single read port of the breakpoint memory,
// each breakpoint taking a read state and a compare state, until a breakpoint
// at or above the sample stops the scan or the sample lies above the whole
// curve. An exact hit adds the angle read. An interpolation adds the angle
// read, two multiply steps on the one shared 16x17 multiplier and a 34-step
// serial divider. The block takes one item at a time; in_ready is high only
// between items. The result sits in an output register, and the next item
// may be accepted while it waits. Table entries are not cleared at reset and
// must be loaded before a convert reads them.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module calibrated_adc_to_angle_interp import caai_pkg::*; #(
	parameter int POINTS = 32,
	parameter int JOINTS = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       cfg_we,
	input  wire logic signed [ANGLE_W-1:0]  cfg_wdata,
	// input channel
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire logic        [OP_W-1:0]     op,
	input  wire logic        [JOINT_W-1:0]  joint,
	input  wire logic                       direction,
	input  wire logic        [PIDX_W-1:0]   point_index,
	input  wire logic        [CODE_W-1:0]   breakpoint_code,
	input  wire logic signed [ANGLE_W-1:0]  angle_point,
	input  wire logic        [SAMPLE_W-1:0] adc_sample,
	// output channel
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	output      logic signed [ANGLE_W-1:0]  angle,
	output      logic        [STATUS_W-1:0] status
);

	localparam int PW       = $clog2(POINTS);
	localparam int BP_DEPTH = JOINTS * 2 * POINTS;
	localparam int AW       = $clog2(BP_DEPTH);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN_RD  = 8'b0000_0010,
		S_SCAN_CMP = 8'b0000_0100,
		S_A1_RD    = 8'b0000_1000,
		S_MUL1     = 8'b0001_0000,
		S_MUL2     = 8'b0010_0000,
		S_DIV      = 8'b0100_0000,
		S_FINISH   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic signed [ANGLE_W-1:0]  above_q;

	logic [CODE_W-1:0]          bp_mem [BP_DEPTH];
	logic [ANGLE_W-1:0]         ang_mem [POINTS];
	logic [CODE_W-1:0]          bp_rd_q;
	logic signed [ANGLE_W-1:0]  ang_rd_q;

	logic [AW-1:0]              base_q;
	logic [PW-1:0]              idx_q;
	logic [CODE_W-1:0]          s16_q;
	logic [CODE_W-1:0]          prev_q;
	logic [CODE_W-1:0]          b1_q;
	logic                       exact_q;
	logic signed [PROD_W-1:0]   acc_q;

	logic signed [ANGLE_W-1:0]  res_angle_q;
	logic [STATUS_W-1:0]        res_status_q;
	logic                       out_valid_q;
	logic signed [ANGLE_W-1:0]  angle_q;
	logic [STATUS_W-1:0]        status_q;

	logic                       in_xfer;
	logic                       joint_ok;
	logic                       pidx_ok;
	logic [AW-1:0]              base_d;
	logic                       bp_we;
	logic                       ang_we;
	logic                       cvt_start;
	logic [AW-1:0]              bp_raddr;
	logic [PW-1:0]              ang_raddr;
	logic                       out_free;

	logic [DIFF_W-1:0]          diff_lo;
	logic [DIFF_W-1:0]          diff_hi;
	logic [DIFF_W-1:0]          mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [NUM_W-1:0]    num_d;
	logic [CODE_W-1:0]          den_d;
	logic                       div_start;
	div_stat_t                  div_stat;
	logic signed [ANGLE_W-1:0]  div_quot;

	// input decode
	always_comb begin
		in_xfer   = in_valid && in_ready;
		joint_ok  = 32'(joint) < JOINTS;
		pidx_ok   = 32'(point_index) < POINTS;
		base_d    = AW'({joint, direction}) * AW'(POINTS);
		bp_we     = in_xfer && (op == OP_LOAD_BREAK) && joint_ok && pidx_ok;
		ang_we    = in_xfer && (op == OP_LOAD_ANGLE) && pidx_ok;
		cvt_start = in_xfer && (op == OP_CONVERT) && joint_ok;
		out_free  = !out_valid_q || out_ready;
	end

	assign in_ready = (state_q == S_IDLE);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= '0;
		end else if (cfg_we) begin
			above_q <= cfg_wdata;
		end
	end

	// table read addresses
	always_comb begin
		bp_raddr  = base_q + AW'(idx_q);
		ang_raddr = (state_q == S_MUL1) ? (idx_q - PW'(1)) : idx_q;
	end

	// breakpoint memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (bp_we) begin
			bp_mem[base_d + AW'(point_index)] <= breakpoint_code;
		end
		bp_rd_q <= bp_mem[bp_raddr];
	end

	// angle point memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (ang_we) begin
			ang_mem[PW'(point_index)] <= angle_point;
		end
		ang_rd_q <= $signed(ang_mem[ang_raddr]);
	end

	// shared multiplier: angle point times code distance
	always_comb begin
		diff_lo = {1'b0, s16_q} - {1'b0, prev_q};
		diff_hi = {1'b0, b1_q} - {1'b0, s16_q};
		mul_b   = (state_q == S_MUL1) ? diff_lo : diff_hi;
		prod    = ang_rd_q * $signed(mul_b);
		num_d   = NUM_W'(acc_q) + NUM_W'(prod);
		den_d   = b1_q - prev_q;
		div_start = (state_q == S_MUL2);
	end

	caai_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_d),
		.den    (den_d),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cvt_start) begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (s16_q > bp_rd_q) begin
						state_q <= (idx_q == PW'(POINTS - 1)) ? S_FINISH : S_SCAN_RD;
					end else if (s16_q == bp_rd_q) begin
						state_q <= S_A1_RD;
					end else if (idx_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_A1_RD;
					end
				end
				S_A1_RD: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= exact_q ? S_FINISH : S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan and interpolation working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				base_q  <= base_d;
				idx_q   <= '0;
				s16_q   <= {adc_sample, FRAC_W'(0)};
				exact_q <= 1'b0;
			end
			S_SCAN_CMP: begin
				if (s16_q > bp_rd_q) begin
					prev_q <= bp_rd_q;
					if (idx_q == PW'(POINTS - 1)) begin
						res_angle_q  <= above_q;
						res_status_q <= STAT_ABOVE;
					end else begin
						idx_q <= idx_q + PW'(1);
					end
				end else begin
					b1_q    <= bp_rd_q;
					exact_q <= (s16_q == bp_rd_q);
					if ((s16_q != bp_rd_q) && (idx_q == '0)) begin
						res_angle_q  <= '0;
						res_status_q <= STAT_BELOW;
					end
				end
			end
			S_MUL1: begin
				acc_q <= prod;
				if (exact_q) begin
					res_angle_q  <= ang_rd_q;
					res_status_q <= STAT_EXACT;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					res_angle_q  <= div_quot;
					res_status_q <= STAT_INTERP;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && out_free) begin
			angle_q  <= res_angle_q;
			status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign status    = status_q;

	`ASSERT_PROP(a_below_zero, clk, arst_n,
		out_valid_q && (status_q == STAT_BELOW) |-> (angle_q == '0),
		"below-table result carries a nonzero angle")
	`ASSERT_NEVER(a_div_done_state, clk, arst_n, div_stat.done && (state_q != S_DIV),
		"divider finished outside the divide state")
	`ASSERT_PROP(a_den_positive, clk, arst_n, div_start |-> (b1_q > prev_q),
		"interpolation started without bracketing breakpoints")

endmodule

`default_nettype wire
